@@ src/lpde_pkg.sv @@
// Shared types and constants for the lattice probe difference encoder.
// Holds operation and result kind codes, the controller state type and the
// command/status structs that join the controller and the datapath.
package lpde_pkg;

  // Default sizes of the stores and the coordinate width.
  localparam int STORE_WORDS_DEF = 4096;
  localparam int MAX_RUN_DEF     = 64;
  localparam int COORD_BITS_DEF  = 8;

  // Fixed field widths.
  localparam int DIM_W  = 5;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 5;
  localparam int OP_W   = 2;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_EMIT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_REM     = 3'd0,
    KIND_NEG     = 3'd1,
    KIND_NEG_END = 3'd2,
    KIND_POS     = 3'd3,
    KIND_POS_END = 3'd4,
    KIND_NONE    = 3'd5,
    KIND_FULL    = 3'd6
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_FULL,
    S_DIV,
    S_CHECK,
    S_NONE,
    S_MUL,
    S_RDT,
    S_RDS,
    S_DIFF,
    S_PUSH,
    S_REM,
    S_NRD,
    S_NOUT,
    S_NEND,
    S_PRD,
    S_POUT,
    S_PEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  store_wr;
    logic  clear;
    logic  start;
    logic  calc;
    logic  mul;
    logic  rd_t;
    logic  rd_s;
    logic  diff;
    logic  push_unit;
    logic  col_next;
    logic  rptr_clr;
    logic  rd_buf;
    logic  rptr_next;
    logic  out_push;
    kind_e out_kind;
    logic  out_last;
    logic  index_inc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic none;
    logic div_done;
    logic units_zero;
    logic col_last;
    logic buf_end;
    logic buf_neg;
    logic out_free;
  } stat_t;

endpackage

@@ src/lpde_ctrl.sv @@
// Controller state machine of the lattice probe difference encoder.
// Sequences load, clear and emit operations; depends on lpde_pkg.
module lpde_ctrl import lpde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = KIND_REM;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_LOAD: begin
            if (stat_i.full) begin
              state_d = S_FULL;
            end else begin
              cmd_o.store_wr = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_EMIT: begin
            cmd_o.start = 1'b1;
            state_d = S_DIV;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FULL: begin
        if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_FULL;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.none) begin
          state_d = S_NONE;
        end else begin
          cmd_o.calc = 1'b1;
          state_d = S_MUL;
        end
      end
      S_NONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_NONE;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_RDT;
      end
      S_RDT: begin
        cmd_o.rd_t = 1'b1;
        state_d = S_RDS;
      end
      S_RDS: begin
        cmd_o.rd_s = 1'b1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_PUSH;
      end
      // One kept unit per cycle, then on to the next column.
      S_PUSH: begin
        if (stat_i.units_zero) begin
          cmd_o.col_next = 1'b1;
          state_d = stat_i.col_last ? S_REM : S_RDT;
        end else begin
          cmd_o.push_unit = 1'b1;
        end
      end
      S_REM: begin
        if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_REM;
          cmd_o.rptr_clr = 1'b1;
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        if (stat_i.buf_end) begin
          state_d = S_NEND;
        end else begin
          cmd_o.rd_buf = 1'b1;
          state_d = S_NOUT;
        end
      end
      S_NOUT: begin
        if (!stat_i.buf_neg) begin
          cmd_o.rptr_next = 1'b1;
          state_d = S_NRD;
        end else if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_NEG;
          cmd_o.rptr_next = 1'b1;
          state_d = S_NRD;
        end
      end
      S_NEND: begin
        if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_NEG_END;
          cmd_o.rptr_clr = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        if (stat_i.buf_end) begin
          state_d = S_PEND;
        end else begin
          cmd_o.rd_buf = 1'b1;
          state_d = S_POUT;
        end
      end
      S_POUT: begin
        if (stat_i.buf_neg) begin
          cmd_o.rptr_next = 1'b1;
          state_d = S_PRD;
        end else if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_POS;
          cmd_o.rptr_next = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PEND: begin
        if (stat_i.out_free) begin
          cmd_o.out_push = 1'b1;
          cmd_o.out_kind = KIND_POS_END;
          cmd_o.out_last = 1'b1;
          cmd_o.index_inc = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ src/lpde_dp.sv @@
// Datapath of the lattice probe difference encoder: probe store, index
// divider, orbit flip, column buffer and output register; uses lpde_pkg.
module lpde_dp import lpde_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [DIM_W-1:0]             dims_i,
  input  logic [OP_W-1:0]              operation_i,
  input  logic signed [COORD_BITS-1:0] coordinate_i,
  input  logic                         out_stall_i,
  input  cmd_t                         cmd_i,
  output stat_t                        stat_o,
  output logic                         out_valid_o,
  output logic [KIND_W-1:0]            kind_o,
  output logic [VAL_W-1:0]             value_o,
  output logic                         last_o,
  output logic                         overflow_o
);

  localparam int CW  = $clog2(STORE_WORDS + 1);
  localparam int MW  = $clog2(STORE_WORDS);
  localparam int TW  = CW + 1;
  localparam int AW  = CW + 7;
  localparam int DW  = COORD_BITS + 1;
  localparam int BD  = MAX_RUN - 3;
  localparam int BW  = $clog2(BD);
  localparam int PW  = $clog2(BD + 1);
  localparam int XW  = DW + PW;
  localparam int DCW = $clog2(CW + 1);

  // Divisor-sized values: dims+1 and twice that.
  logic [DIM_W:0]   dimp;
  logic [DIM_W+1:0] dimp2;
  assign dimp  = {1'b0, dims_i} + 1'b1;
  assign dimp2 = {dimp, 1'b0};

  op_e                    op_q;
  logic [COORD_BITS-1:0]  coord_q;
  logic [CW-1:0]          count_q, index_q;
  logic [AW-1:0]          chk_q;

  // Input capture and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_NOP;
      count_q <= '0;
      index_q <= CW'(1);
    end else begin
      if (cmd_i.accept) begin
        op_q <= op_e'(operation_i);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        index_q <= CW'(1);
      end else begin
        if (cmd_i.store_wr) begin
          count_q <= count_q + 1'b1;
        end
        if (cmd_i.index_inc) begin
          index_q <= index_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      coord_q <= coordinate_i;
    end
    // Entry exists only if (index+1)*(dims+1) coordinates are loaded.
    if (cmd_i.start) begin
      chk_q <= (AW'(index_q) + AW'(1)) * AW'(dimp);
    end
  end

  // Restoring divider, one quotient bit per cycle: index mod 2*(dims+1).
  logic [DIM_W+1:0] rem_q;
  logic [CW-1:0]    num_q;
  logic [DCW-1:0]   dcnt_q;
  logic             dbusy_q;
  logic [DIM_W+2:0] rem_sh;
  assign rem_sh = {rem_q, num_q[CW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= DCW'(CW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DCW'(1)) begin
        dbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= '0;
      num_q <= index_q;
    end else if (dbusy_q) begin
      num_q <= {num_q[CW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dimp2}) begin
        rem_q <= (DIM_W+2)'(rem_sh - {1'b0, dimp2});
      end else begin
        rem_q <= (DIM_W+2)'(rem_sh);
      end
    end
  end

  // Orbit flip of the source and target positions, and the remainder value.
  logic [DIM_W+1:0] jprev;
  logic [TW-1:0]    s_d, t_d, s_q, t_q;
  logic [DIM_W+1:0] r_full;
  logic [VAL_W-1:0] r_q;
  logic [TW-1:0]    ibase;

  assign jprev = (rem_q == '0) ? (dimp2 - 1'b1) : (rem_q - 1'b1);
  assign ibase = TW'(index_q) + TW'(dimp2) + TW'(dimp) - TW'(1);

  always_comb begin
    if (jprev < {1'b0, dimp}) begin
      s_d = TW'(index_q) - TW'(1);
    end else begin
      s_d = ibase - TW'(1) - (TW'(jprev) << 1);
    end
    if (rem_q < {1'b0, dimp}) begin
      t_d = TW'(index_q);
      r_full = rem_q;
    end else begin
      t_d = ibase - (TW'(rem_q) << 1);
      r_full = (DIM_W+2)'({dims_i, 1'b1}) - rem_q;
    end
  end

  // Column scan: read both probes, take the difference, keep units.
  logic [COORD_BITS-1:0] mem [STORE_WORDS];
  logic [COORD_BITS-1:0] mem_q;
  logic                  inr_q;
  logic [AW-1:0]         tbase_q, sbase_q, rd_addr;
  logic [DIM_W-1:0]      col_q;
  logic [COORD_BITS-1:0] tval_q;
  logic [BW-1:0]         wptr_q, rptr_q;
  logic [PW-1:0]         remain_q, wcnt_q, rcnt_q;
  logic [DW-1:0]         units_q;
  logic                  sign_q, dropped_q;

  assign rd_addr = (cmd_i.rd_t ? tbase_q : sbase_q) + AW'(col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem[count_q[MW-1:0]] <= coord_q;
    end
    if (cmd_i.rd_t || cmd_i.rd_s) begin
      mem_q <= mem[rd_addr[MW-1:0]];
      inr_q <= (rd_addr < AW'(count_q));
    end
  end

  logic signed [DW-1:0] tv, sv, diff;
  logic [DW-1:0]        absd;
  logic [XW-1:0]        absx, remx;
  assign tv   = DW'($signed(tval_q));
  assign sv   = inr_q ? DW'($signed(mem_q)) : '0;
  assign diff = tv - sv;
  assign absd = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign absx = XW'(absd);
  assign remx = XW'(remain_q);

  logic [VAL_W:0] buf_mem [BD];
  logic [VAL_W:0] buf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      s_q <= s_d;
      t_q <= t_d;
      r_q <= r_full[VAL_W-1:0];
    end
    if (cmd_i.mul) begin
      tbase_q <= AW'(t_q) * AW'(dimp);
      sbase_q <= AW'(s_q) * AW'(dimp);
    end
    if (cmd_i.rd_s) begin
      tval_q <= inr_q ? mem_q : '0;
    end
    if (cmd_i.calc) begin
      col_q     <= '0;
      wptr_q    <= '0;
      wcnt_q    <= '0;
      remain_q  <= PW'(BD);
      dropped_q <= 1'b0;
    end else begin
      if (cmd_i.col_next) begin
        col_q <= col_q + 1'b1;
      end
      if (cmd_i.diff) begin
        sign_q <= diff[DW-1];
        if (absx > remx) begin
          units_q   <= DW'(remx);
          remain_q  <= '0;
          dropped_q <= 1'b1;
        end else begin
          units_q  <= absd;
          remain_q <= PW'(remx - absx);
        end
      end
      if (cmd_i.push_unit) begin
        buf_mem[wptr_q] <= {sign_q, col_q};
        wptr_q  <= wptr_q + 1'b1;
        wcnt_q  <= wcnt_q + 1'b1;
        units_q <= units_q - 1'b1;
      end
    end
    if (cmd_i.rptr_clr) begin
      rptr_q <= '0;
      rcnt_q <= '0;
    end else if (cmd_i.rptr_next) begin
      rptr_q <= rptr_q + 1'b1;
      rcnt_q <= rcnt_q + 1'b1;
    end
    if (cmd_i.rd_buf) begin
      buf_q <= buf_mem[rptr_q];
    end
  end

  // Output register.
  logic              ovalid_q, out_free;
  logic [KIND_W-1:0] okind_q;
  logic [VAL_W-1:0]  oval_q, oval_d;
  logic              olast_q, oovf_q, oovf_d;

  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.out_kind)
      KIND_REM:               oval_d = r_q;
      KIND_NEG, KIND_POS:     oval_d = buf_q[VAL_W-1:0];
      default:                oval_d = '0;
    endcase
    case (cmd_i.out_kind)
      KIND_NONE, KIND_FULL:   oovf_d = 1'b0;
      default:                oovf_d = dropped_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      okind_q <= cmd_i.out_kind;
      oval_q  <= oval_d;
      olast_q <= cmd_i.out_last;
      oovf_q  <= oovf_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign value_o     = oval_q;
  assign last_o      = olast_q;
  assign overflow_o  = oovf_q;

  // Status to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.full       = (count_q >= CW'(STORE_WORDS));
    stat_o.none       = (chk_q > AW'(count_q));
    stat_o.div_done   = !dbusy_q;
    stat_o.units_zero = (units_q == '0);
    stat_o.col_last   = (col_q == dims_i);
    stat_o.buf_end    = (rcnt_q == wcnt_q);
    stat_o.buf_neg    = buf_q[VAL_W];
    stat_o.out_free   = out_free;
  end

endmodule

@@ src/lattice_probe_diff_encoder_core.sv @@
// Lattice probe difference encoder, top level. An emit first runs the
// bit-serial index divider and the orbit flip, then scans each column of
// the two probes and keeps its units in the column buffer, then emits the
// remainder and sweeps the column buffer twice, for negative and then
// positive units, each sweep closed by its terminator.
// One item is in work at a time. Reset (asynchronous, active low) empties the
// store, sets the index to 1 and dimensions to 1; the store is not cleared.
module lattice_probe_diff_encoder_core import lpde_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [APB_W-1:0]             pwdata,
  output logic [APB_W-1:0]             prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [OP_W-1:0]              operation_i,
  input  logic signed [COORD_BITS-1:0] coordinate_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [KIND_W-1:0]            kind_o,
  output logic [VAL_W-1:0]             value_o,
  output logic                         last_o,
  output logic                         overflow_o
);

  logic [DIM_W-1:0] dims_q;
  cmd_t             cmd;
  stat_t            stat;

  // Dimensions register at byte address zero, decoded on the top address bit only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIM_W'(1);
    end else if (psel && penable && pwrite && !paddr[ADDR_W-1]) begin
      dims_q <= pwdata[DIM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[ADDR_W-1] ? '0 : APB_W'(dims_q);

  lpde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lpde_dp #(
    .STORE_WORDS (STORE_WORDS),
    .MAX_RUN     (MAX_RUN),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims_q),
    .operation_i  (operation_i),
    .coordinate_i (coordinate_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .overflow_o   (overflow_o)
  );

endmodule

@@ tb/lattice_probe_diff_encoder_core_tb.sv @@
// Self-checking testbench for the lattice probe difference encoder core.
// Depends on lpde_pkg for the operation and result kind codes.
`timescale 1ns / 100ps

module lattice_probe_diff_encoder_core_tb;
  import lpde_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int RUN_LIMIT   = 64;
  localparam int WATCH_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam logic [ADDR_W-1:0] REG_DIMENSIONS = '0;

  typedef struct {
    op_e             op;
    logic [7:0]      coord;
  } cmd_item_t;

  typedef struct {
    kind_e           kind;
    logic [VAL_W-1:0] value;
    logic            last;
    logic            overflow;
  } run_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] operation_i = OP_NOP;
  logic signed [7:0] coordinate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [VAL_W-1:0] value_o;
  logic last_o, overflow_o;

  // Predictor state.
  logic signed [7:0] probe_mem [STORE_DEPTH];
  int unsigned coord_count;
  int unsigned entry_index;
  logic [4:0] dims;

  cmd_item_t cmd_q[$];
  run_word_t run_q[$];
  cmd_item_t cur;
  bit cur_taken;
  int errors;
  int gap_left, stall_left;
  bit no_idle, hold_arm;
  int n_emit, n_overflow, n_full, n_none, n_words;

  lattice_probe_diff_encoder_core u_dut (.*);

  always #1 clk_i = ~clk_i;

  // Coordinate read with unloaded addresses returning zero.
  function automatic int coord_at(longint unsigned addr);
    if (addr >= coord_count || addr >= STORE_DEPTH) return 0;
    return probe_mem[addr];
  endfunction

  function automatic longint unsigned orbit_flip(longint unsigned i, longint unsigned dp);
    longint unsigned j;
    j = i % (2 * dp);
    return (j < dp) ? i : i - j - j + 2 * dp + dp - 1;
  endfunction

  function automatic void push_word(kind_e k, int v);
    run_word_t w;
    w.kind = k;
    w.value = v[VAL_W-1:0];
    w.last = 1'b0;
    w.overflow = 1'b0;
    run_q.push_back(w);
  endfunction

  // Works out the results of one accepted item and updates the predictor state.
  function automatic void encode_entry(cmd_item_t it);
    longint unsigned dp, i, s, t, r, nprobes;
    int diff, taken, npos, first;
    int pos_cols[RUN_LIMIT];
    bit dropped;
    case (it.op)
      OP_LOAD: begin
        if (coord_count >= STORE_DEPTH) begin
          push_word(KIND_FULL, 0);
          run_q[$].last = 1'b1;
          n_full++;
        end else begin
          probe_mem[coord_count] = it.coord;
          coord_count++;
        end
      end
      OP_CLEAR: begin
        coord_count = 0;
        entry_index = 1;
      end
      OP_EMIT: begin
        dp = dims + 1;
        nprobes = coord_count / dp;
        i = entry_index;
        if (i >= nprobes) begin
          push_word(KIND_NONE, 0);
          run_q[$].last = 1'b1;
          n_none++;
        end else begin
          n_emit++;
          first = run_q.size();
          s = orbit_flip(i - 1, dp);
          t = orbit_flip(i, dp);
          r = (i % (2 * dp) < dp) ? (i % dp) : (dims - i % dp);
          push_word(KIND_REM, int'(r));
          taken = 0;
          npos = 0;
          dropped = 1'b0;
          for (int d = 0; d < dp; d++) begin
            diff = coord_at(t * dp + d) - coord_at(s * dp + d);
            while (diff != 0) begin
              if (taken < RUN_LIMIT - 3) begin
                if (diff < 0) push_word(KIND_NEG, d);
                else pos_cols[npos++] = d;
                taken++;
              end else begin
                dropped = 1'b1;
              end
              diff += (diff < 0) ? 1 : -1;
            end
          end
          push_word(KIND_NEG_END, 0);
          for (int d = 0; d < npos; d++) push_word(KIND_POS, pos_cols[d]);
          push_word(KIND_POS_END, 0);
          for (int k = first; k < run_q.size(); k++) run_q[k].overflow = dropped;
          run_q[$].last = 1'b1;
          if (dropped) n_overflow++;
          entry_index = i + 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input side: accept at the rising edge, present the next item at the falling edge.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      encode_entry(cur);
      cur_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || cur_taken) begin
      cur_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur = cmd_q.pop_front();
        operation_i <= cur.op;
        coordinate_i <= cur.coord;
        in_valid_i <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off while items keep coming.
  always @(negedge clk_i) begin
    if (hold_arm && run_q.size() > 0 && cmd_q.size() > 0) begin
      hold_arm = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    run_word_t w;
    if (out_valid_o && !out_stall_i) begin
      n_words++;
      if (run_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%0d last=%0b overflow=%0b",
                 $time, kind_o, value_o, last_o, overflow_o);
        errors++;
      end else begin
        w = run_q.pop_front();
        if (kind_o !== w.kind || value_o !== w.value || last_o !== w.last ||
            overflow_o !== w.overflow) begin
          $display("%0t: mismatch expected kind=%0d value=%0d last=%0b overflow=%0b",
                   $time, w.kind, w.value, w.last, w.overflow);
          $display("%0t:          actual   kind=%0d value=%0d last=%0b overflow=%0b",
                   $time, kind_o, value_o, last_o, overflow_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet = 0;
    else quiet++;
    if (quiet >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_dims(logic [4:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_DIMENSIONS;
    pwdata <= APB_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    dims = v;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every item is taken and every result has arrived.
  task automatic drain();
    do @(posedge clk_i);
    while (cmd_q.size() > 0 || in_valid_i || run_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add(op_e op, int c);
    cmd_item_t it;
    it.op = op;
    it.coord = c[7:0];
    cmd_q.push_back(it);
  endtask

  // Well-formed sequence: clear, whole probes, emits until none is left, some noise.
  task automatic add_sequence(int probes, int spread, int extra_coords);
    int dp;
    dp = dims + 1;
    add(OP_CLEAR, $urandom);
    for (int p = 0; p < probes * dp + extra_coords; p++) begin
      if ($urandom_range(0, 19) == 0) add(OP_NOP, $urandom);
      if ($urandom_range(0, 9) == 0) add(OP_LOAD, $urandom);
      else add(OP_LOAD, $urandom_range(0, 2 * spread) - spread);
    end
    for (int e = 0; e < probes + 1; e++) add(OP_EMIT, $urandom);
  endtask

  initial begin
    coord_count = 0;
    entry_index = 1;
    dims = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes with 2-coordinate probes, emits past the end.
    write_dims(5'd1);
    add(OP_EMIT, 0);
    add(OP_LOAD, -128); add(OP_LOAD, 127);
    add(OP_LOAD, 127);  add(OP_LOAD, -128);
    add(OP_LOAD, 0);    add(OP_LOAD, 0);
    add(OP_LOAD, -1);   add(OP_LOAD, 1);
    add(OP_LOAD, 85);
    add(OP_NOP, -86);
    repeat (5) add(OP_EMIT, 0);
    add(OP_CLEAR, 0);
    add(OP_EMIT, 0);
    drain();

    // Widest and degenerate probe shapes.
    write_dims(5'd31);
    add_sequence(2, 2, 0);
    drain();
    write_dims(5'd0);
    add_sequence(4, 3, 0);
    drain();

    // Random part with small dimensions and one long receiver hold-off.
    hold_arm = 1'b1;
    for (int ph = 0; ph < 2; ph++) begin
      no_idle = (ph == 1);
      write_dims(5'($urandom_range(1, 3)));
      add_sequence($urandom_range(2, 3), (ph == 1) ? 128 : $urandom_range(1, 4),
                   $urandom_range(0, 2));
      drain();
    end
    no_idle = 1'b0;

    repeat (600) @(posedge clk_i);
    $display("Checked %0d results: %0d encoded entries (%0d with dropped columns),",
             n_words, n_emit, n_overflow);
    $display("%0d exhausted-index replies and %0d full-store replies.", n_none, n_full);
    if (errors == 0 && run_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lpde_pkg.sv
src/lpde_ctrl.sv
src/lpde_dp.sv
src/lattice_probe_diff_encoder_core.sv
tb/lattice_probe_diff_encoder_core_tb.sv
